/* rtl/core/fnvh_pkg.sv */
// Package for the FNV-1a hash block: constants and the hash arithmetic.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package fnvh_pkg;

    localparam int unsigned HashW = 32;
    localparam int unsigned ByteW = 8;

    typedef logic [HashW-1:0] hash_t;
    typedef logic [ByteW-1:0] byte_t;

    localparam hash_t FNV_BASIS = 32'h811C_9DC5;
    // 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0
    localparam hash_t FNV_PRIME = 32'h0100_0193;

    // Multiply by the FNV prime mod 2^32 as a sum of shifted copies
    function automatic hash_t fnv_mul(input hash_t h);
        fnv_mul = (h << 24) + (h << 8) + (h << 7) + (h << 4) + (h << 1) + h;
    endfunction

    // Five-step shift/add/xor finaliser, all mod 2^32
    function automatic hash_t avalanche(input hash_t h_in);
        hash_t h;
        h = h_in;
        h = h + (h << 13);
        h = h ^ (h >> 7);
        h = h + (h << 3);
        h = h ^ (h >> 17);
        h = h + (h << 5);
        avalanche = h;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fnvh_finalizer.sv */
// Finaliser stage: holds the folded hash of a finished string, applies the
// avalanche mix and presents the result beat. Depends on fnvh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fnvh_finalizer
    import fnvh_pkg::*;
(
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   in_valid,
    output logic  in_ready,
    input  hash_t in_hash,
    output logic  out_valid,
    input  wire   out_ready,
    output hash_t out_hash
);

    logic  b_valid_reg;
    hash_t b_hash_reg;
    logic  o_valid_reg;
    hash_t o_hash_reg;
    logic  o_free;
    logic  b_move;

    assign o_free   = !o_valid_reg || out_ready;
    assign b_move   = b_valid_reg && o_free;
    assign in_ready = !b_valid_reg || o_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                b_valid_reg <= in_valid;
            end
            if (o_free) begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            b_hash_reg <= in_hash;
        end
        if (b_move) begin
            o_hash_reg <= avalanche(b_hash_reg);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_hash  = o_hash_reg;

endmodule

`default_nettype wire

/* rtl/core/fnv1a_hash_with_avalanche.sv */
// Top level of the FNV-1a string hash with avalanche finaliser.
// Depends on fnvh_pkg and fnvh_finalizer.
`timescale 1ns / 1ps
`default_nettype none

// Takes one string byte per beat and keeps a 32-bit FNV-1a running hash
// (basis 0x811C9DC5). A beat with s_last produces exactly one result beat:
// the finalised hash, or 0 when s_absent_string is set; the running hash
// then returns to the basis. Throughput is one beat per cycle, set by the
// running-hash loop (xor plus constant multiply done as shifted adds),
// while no last beat waits on the finaliser. With no stall, the edge that
// accepts a last beat loads the input register, and the finaliser input
// register and then the result register follow; the latter drives m_valid.
// cfg_wr_data selects sign extension of bytes above 127; write it only
// while the block is idle.
module fnv1a_hash_with_avalanche
    import fnvh_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire         cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [7:0]  s_data_byte,
    input  wire         s_byte_present,
    input  wire         s_last,
    input  wire         s_absent_string,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_hash_value
);

    logic  sign_ext_reg;
    logic  a_valid_reg;
    byte_t a_byte_reg;
    logic  a_present_reg;
    logic  a_last_reg;
    logic  a_absent_reg;
    hash_t hash_reg;
    hash_t hash_next;
    hash_t byte_ext;
    hash_t folded;
    hash_t fin_hash;
    logic  fin_ready;
    logic  a_fire;

    assign a_fire  = a_valid_reg && (!a_last_reg || fin_ready);
    assign s_ready = !a_valid_reg || a_fire;

    always_comb begin
        byte_ext  = {{(HashW-ByteW){sign_ext_reg & a_byte_reg[ByteW-1]}}, a_byte_reg};
        folded    = a_present_reg ? fnv_mul(hash_reg ^ byte_ext) : hash_reg;
        fin_hash  = a_absent_reg ? '0 : folded;
        hash_next = a_last_reg ? FNV_BASIS : folded;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_ext_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
            hash_reg     <= FNV_BASIS;
        end else begin
            if (cfg_wr_en) begin
                sign_ext_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                a_valid_reg <= s_valid;
            end
            if (a_fire) begin
                hash_reg <= hash_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_byte_reg    <= s_data_byte;
            a_present_reg <= s_byte_present;
            a_last_reg    <= s_last;
            a_absent_reg  <= s_absent_string;
        end
    end

    fnvh_finalizer u_finalizer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg && a_last_reg),
        .in_ready  (fin_ready),
        .in_hash   (fin_hash),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_hash  (m_hash_value)
    );

endmodule

`default_nettype wire

/* rtl/core/fnvh_checker.sv */
// Port-level checker for fnv1a_hash_with_avalanche, bound to the top level.
// Depends on fnvh_pkg for the hash width only.
`timescale 1ns / 1ps
`default_nettype none

module fnvh_checker
    import fnvh_pkg::*;
(
    input wire         aclk,
    input wire         aresetn,
    input wire         s_valid,
    input wire         s_ready,
    input wire         s_last,
    input wire         m_valid,
    input wire         m_ready,
    input wire  [HashW-1:0] m_hash_value
);

    // last beats taken minus result beats delivered
    logic [2:0] pend_reg;
    logic [2:0] pend_next;

    always_comb begin
        pend_next = pend_reg;
        if (s_valid && s_ready && s_last) begin
            pend_next = pend_next + 3'd1;
        end
        if (m_valid && m_ready) begin
            pend_next = pend_next - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hash_value))
        else $error("stalled result beat dropped or changed");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 3'd0)
        else $error("result beat without a pending last beat");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd3)
        else $error("more strings in flight than pipeline stages");

endmodule

bind fnv1a_hash_with_avalanche fnvh_checker u_fnvh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s_last       (s_last),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_hash_value (m_hash_value)
);

`default_nettype wire

/* tb/fnv1a_hash_with_avalanche_tb.sv */
// Self-checking testbench for fnv1a_hash_with_avalanche: a directed table,
// then random strings. Every hash is predicted locally and checked in order.
// Depends on fnvh_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module fnv1a_hash_with_avalanche_tb
    import fnvh_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT    = 300000;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned PHASE_ITEMS    = 242;
    localparam int unsigned RANDOM_PHASES  = 6;

    typedef struct packed {
        byte_t data;
        logic  present;
        logic  last;
        logic  absent;
    } beat_t;

    // sext, data, present, last, absent, typed expectation, expected hash
    typedef struct packed {
        logic  sext;
        byte_t data;
        logic  present;
        logic  last;
        logic  absent;
        logic  typed;
        hash_t value;
    } dir_row_t;

    localparam int DIR_N = 21;
    localparam dir_row_t DIR_TABLE [DIR_N] = '{
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0}, // empty string from the basis
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0}, // absent string
        '{1'b0, 8'h41, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0}, // zero byte is data
        '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'hFF, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0}, // absent flag ignored mid-string
        '{1'b0, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'h55, 1'b0, 1'b0, 1'b1, 1'b0, 32'h0}, // no byte, not last: nothing
        '{1'b0, 8'hAA, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0}, // absent drops byte and history
        '{1'b0, 8'h01, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0}, // end-only after bytes
        '{1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'h80, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'hC3, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'hFE, 1'b1, 1'b0, 1'b0, 1'b0, 32'h0},
        '{1'b1, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0},
        '{1'b0, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0}
    };

    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        cfg_wr_en       = 1'b0;
    logic        cfg_wr_data     = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte     = 8'h00;
    logic        s_byte_present  = 1'b0;
    logic        s_last          = 1'b0;
    logic        s_absent_string = 1'b0;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic [31:0] m_hash_value;

    fnv1a_hash_with_avalanche dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_byte_present  (s_byte_present),
        .s_last          (s_last),
        .s_absent_string (s_absent_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hash_value    (m_hash_value)
    );

    hash_t       model_hash = FNV_BASIS;
    logic        sext_shadow = 1'b0;
    hash_t       pending_hashes[$];
    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned cycles      = 0;
    int unsigned rx_left     = 0;
    int unsigned rx_mode     = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic hash_t finalise(input hash_t h_in);
        hash_t h;
        h = h_in;
        h = h + (h << 13);
        h = h ^ (h >> 7);
        h = h + (h << 3);
        h = h ^ (h >> 17);
        h = h + (h << 5);
        return h;
    endfunction

    // Advances the local hash by one beat; returns 1 when the beat yields a hash
    function automatic logic string_hash_step(input beat_t b, output hash_t res);
        hash_t v;
        res = '0;
        if (b.last && b.absent) begin
            model_hash = FNV_BASIS;
            return 1'b1;
        end
        if (b.present) begin
            v = {24'd0, b.data};
            if (sext_shadow && b.data[7])
                v[31:8] = '1;
            model_hash = (model_hash ^ v) * FNV_PRIME;
        end
        if (b.last) begin
            res = finalise(model_hash);
            model_hash = FNV_BASIS;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic byte_t rand_byte();
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 3))
                0: return 8'h00;
                1: return 8'h7F;
                2: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return byte_t'($urandom_range(0, 255));
    endfunction

    task automatic send_beat(input beat_t b, input logic typed, input hash_t typed_val);
        hash_t h;
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid         <= 1'b1;
        s_data_byte     <= b.data;
        s_byte_present  <= b.present;
        s_last          <= b.last;
        s_absent_string <= b.absent;
        do @(posedge aclk); while (!s_ready);
        if (string_hash_step(b, h))
            pending_hashes.push_back(typed ? typed_val : h);
        items_sent++;
    endtask

    // Hold off the sender until every hash is out, then let the pipe settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        burst_left = 0;
    endtask

    task automatic write_sext(input logic v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sext_shadow = v;
    endtask

    task automatic send_string();
        int unsigned kind;
        int unsigned len;
        beat_t b;
        kind = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        if (kind >= 90) begin
            // noise: a few byte-less beats, then an absent end
            repeat ($urandom_range(1, 4)) begin
                b = '{rand_byte(), 1'b0, 1'b0, 1'($urandom_range(0, 1))};
                send_beat(b, 1'b0, '0);
            end
            len = 0;
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 11) == 0) begin
                b = '{rand_byte(), 1'b0, 1'b0, 1'($urandom_range(0, 1))};
                send_beat(b, 1'b0, '0);
            end
            b = '{rand_byte(), 1'b1, 1'b0, 1'($urandom_range(0, 3) == 0)};
            send_beat(b, 1'b0, '0);
        end
        b = '{rand_byte(), 1'($urandom_range(0, 1)), 1'b1, 1'(kind >= 70)};
        send_beat(b, 1'b0, '0);
    endtask

    initial begin
        beat_t b;
        int unsigned stop_at;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_sext(1'b0);

        for (int i = 0; i < DIR_N; i++) begin
            if (DIR_TABLE[i].sext != sext_shadow) begin
                quiesce();
                write_sext(DIR_TABLE[i].sext);
            end
            b = '{DIR_TABLE[i].data, DIR_TABLE[i].present, DIR_TABLE[i].last,
                  DIR_TABLE[i].absent};
            send_beat(b, DIR_TABLE[i].typed, DIR_TABLE[i].value);
        end
        quiesce();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_sext((p < 2) ? 1'(p == 0) : 1'($urandom_range(0, 1)));
            stop_at = items_sent + PHASE_ITEMS;
            while (items_sent < stop_at) begin
                send_string();
                if ($urandom_range(0, 39) == 0)
                    quiesce();
            end
            quiesce();
        end

        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: switches between free-running, random, periodic and heavy stalling
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 128);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (cycles[2:0] != 3'd0);
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                $error("hash_value: expected nothing, actual %08h", m_hash_value);
                errors++;
            end else begin
                if (m_hash_value !== pending_hashes[0]) begin
                    $error("hash_value: expected %08h, actual %08h",
                           pending_hashes[0], m_hash_value);
                    errors++;
                end
                void'(pending_hashes.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
